FILE: hdl/pkia_pkg.sv
`default_nettype none
package pkia_pkg;

   localparam int DEF_MAX_PATH_LEN    = 16;
   localparam int DEF_WAYS_PER_BUCKET = 4;
   localparam int NUM_BUCKETS         = 256;
   localparam int BKT_W               = $clog2(NUM_BUCKETS);
   localparam int ID_W                = 32;
   localparam int WORD_W              = 64;

   localparam logic [1:0] ST_OK          = 2'd0;
   localparam logic [1:0] ST_BUCKET_FULL = 2'd1;
   localparam logic [1:0] ST_TOO_LONG    = 2'd2;
   localparam logic [1:0] ST_EXHAUSTED   = 2'd3;

   localparam logic [2:0] RES_HIT  = 3'd0;
   localparam logic [2:0] RES_NEW  = 3'd1;
   localparam logic [2:0] RES_FULL = 3'd2;
   localparam logic [2:0] RES_LONG = 3'd3;
   localparam logic [2:0] RES_EXH  = 3'd4;

   typedef logic [2:0] res_kind_type;

   typedef struct packed {
      logic         accept;
      logic         bfill_rd;
      logic         ways_ld;
      logic         ent_rd;
      logic         way_inc;
      logic         idx_clr;
      logic         wrd_rd;
      logic         idx_inc;
      logic         ins;
      logic         copy_wr;
      logic         res_ld;
      res_kind_type res_kind;
   } pkia_cmd_type;

   typedef struct packed {
      logic overflow;
      logic way_end;
      logic bkt_full;
      logic exhausted;
      logic len_eq;
      logic idx_end;
      logic word_eq;
      logic out_busy;
   } pkia_sts_type;

   // Fold the eight bytes of a location into one byte.
   function automatic logic [BKT_W-1:0] fold_bytes(input logic [WORD_W-1:0] w);
      logic [BKT_W-1:0] h;
      h = '0;
      for (int i = 0; i < 8; i++) begin
         h = h ^ w[i*8 +: 8];
      end
      return h;
   endfunction

endpackage
`default_nettype wire

FILE: hdl/pkia_if.sv
`default_nettype none
interface pkia_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] place;
   logic [31:0] count;
   logic        last;
   modport source (output valid, output place, output count, output last, input ready);
   modport sink   (input valid, input place, input count, input last, output ready);
endinterface

interface pkia_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] found_id;
   logic        created;
   logic [1:0]  status;
   modport source (output valid, output found_id, output created, output status,
                   input ready);
   modport sink   (input valid, input found_id, input created, input status,
                   output ready);
endinterface
`default_nettype wire

FILE: hdl/pkia_ctrl.sv
`default_nettype none
module pkia_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_last,
   output logic                       req_ready,
   input  wire pkia_pkg::pkia_sts_type sts,
   output pkia_pkg::pkia_cmd_type     cmd
);
   import pkia_pkg::*;

   localparam logic [3:0] S_IN     = 4'd0;
   localparam logic [3:0] S_BFILL  = 4'd1;
   localparam logic [3:0] S_WAYS   = 4'd2;
   localparam logic [3:0] S_WAY    = 4'd3;
   localparam logic [3:0] S_LEN    = 4'd4;
   localparam logic [3:0] S_WRD    = 4'd5;
   localparam logic [3:0] S_WCHK   = 4'd6;
   localparam logic [3:0] S_MISS   = 4'd7;
   localparam logic [3:0] S_COPY   = 4'd8;
   localparam logic [3:0] S_COPYW  = 4'd9;
   localparam logic [3:0] S_RES    = 4'd10;

   logic [3:0]   state_ff, state_in;
   res_kind_type kind_ff, kind_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IN;
         kind_ff  <= RES_HIT;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
   end

   assign req_ready = (state_ff == S_IN);

   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      cmd      = '0;
      cmd.res_kind = kind_ff;
      unique case (state_ff)
         S_IN: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (req_last) state_in = S_BFILL;
            end
         end
         S_BFILL: begin
            cmd.bfill_rd = 1'b1;
            state_in     = S_WAYS;
         end
         S_WAYS: begin
            cmd.ways_ld = 1'b1;
            if (sts.overflow) begin
               kind_in  = RES_LONG;
               state_in = S_RES;
            end else begin
               state_in = S_WAY;
            end
         end
         S_WAY: begin
            if (sts.way_end) begin
               state_in = S_MISS;
            end else begin
               cmd.ent_rd = 1'b1;
               state_in   = S_LEN;
            end
         end
         S_LEN: begin
            if (sts.len_eq) begin
               cmd.idx_clr = 1'b1;
               state_in    = S_WRD;
            end else begin
               cmd.way_inc = 1'b1;
               state_in    = S_WAY;
            end
         end
         S_WRD: begin
            if (sts.idx_end) begin
               kind_in  = RES_HIT;
               state_in = S_RES;
            end else begin
               cmd.wrd_rd = 1'b1;
               state_in   = S_WCHK;
            end
         end
         S_WCHK: begin
            if (sts.word_eq) begin
               cmd.idx_inc = 1'b1;
               state_in    = S_WRD;
            end else begin
               cmd.way_inc = 1'b1;
               state_in    = S_WAY;
            end
         end
         S_MISS: begin
            if (sts.bkt_full) begin
               kind_in  = RES_FULL;
               state_in = S_RES;
            end else if (sts.exhausted) begin
               kind_in  = RES_EXH;
               state_in = S_RES;
            end else begin
               cmd.ins  = 1'b1;
               kind_in  = RES_NEW;
               state_in = S_COPY;
            end
         end
         S_COPY: begin
            if (sts.idx_end) begin
               state_in = S_RES;
            end else begin
               cmd.wrd_rd = 1'b1;
               state_in   = S_COPYW;
            end
         end
         S_COPYW: begin
            cmd.copy_wr = 1'b1;
            cmd.idx_inc = 1'b1;
            state_in    = S_COPY;
         end
         S_RES: begin
            if (!sts.out_busy) begin
               cmd.res_ld = 1'b1;
               state_in   = S_IN;
            end
         end
         default: state_in = S_IN;
      endcase
   end

endmodule
`default_nettype wire

FILE: hdl/pkia_dp.sv
`default_nettype none
module pkia_dp #(
   parameter int MAX_PATH_LEN    = pkia_pkg::DEF_MAX_PATH_LEN,
   parameter int WAYS_PER_BUCKET = pkia_pkg::DEF_WAYS_PER_BUCKET
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire pkia_pkg::pkia_cmd_type cmd,
   output pkia_pkg::pkia_sts_type     sts,
   input  wire logic [31:0]           req_place,
   input  wire logic [31:0]           req_count,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [31:0]                rsp_found_id,
   output logic                       rsp_created,
   output logic [1:0]                 rsp_status
);
   import pkia_pkg::*;

   localparam int LEN_W   = $clog2(MAX_PATH_LEN + 1);
   localparam int IDX_W   = (MAX_PATH_LEN > 1) ? $clog2(MAX_PATH_LEN) : 1;
   localparam int WAY_W   = $clog2(WAYS_PER_BUCKET + 1);
   localparam int WSEL_W  = (WAYS_PER_BUCKET > 1) ? $clog2(WAYS_PER_BUCKET) : 1;
   localparam int SLOT_W  = BKT_W + WSEL_W;
   localparam int NSLOT   = 2 ** SLOT_W;
   localparam int NWORD   = 2 ** (SLOT_W + IDX_W);
   localparam logic [LEN_W-1:0] MAX_FILL = LEN_W'(MAX_PATH_LEN);
   localparam logic [WAY_W-1:0] WAYS_MAX = WAY_W'(WAYS_PER_BUCKET);

   // Path being assembled.
   logic [WORD_W-1:0] pbuf_mem [MAX_PATH_LEN];
   logic [LEN_W-1:0]  fill_ff;
   logic [BKT_W-1:0]  hash_ff;
   logic              ovf_ff;

   // Table.
   logic [WAY_W-1:0]  bfill_mem [NUM_BUCKETS];
   logic [NUM_BUCKETS-1:0] bvalid_ff;
   logic [LEN_W-1:0]  len_mem [NSLOT];
   logic [ID_W-1:0]   id_mem [NSLOT];
   logic [WORD_W-1:0] words_mem [NWORD];
   logic [ID_W-1:0]   ctr_ff;

   // Read data registers.
   logic [WAY_W-1:0]  bfill_q;
   logic              bvalid_q;
   logic [LEN_W-1:0]  len_q;
   logic [ID_W-1:0]   id_q;
   logic [WORD_W-1:0] word_q;
   logic [WORD_W-1:0] pbuf_q;

   // Search counters.
   logic [WAY_W-1:0]  ways_ff;
   logic [WAY_W-1:0]  way_ff;
   logic [LEN_W-1:0]  idx_ff;

   logic              out_valid_ff;
   logic [ID_W-1:0]   out_id_ff;
   logic              out_created_ff;
   logic [1:0]        out_status_ff;

   logic [WORD_W-1:0] loc;
   logic [SLOT_W-1:0] rd_slot, new_slot;

   assign loc      = {req_place, req_count};
   assign rd_slot  = {hash_ff, way_ff[WSEL_W-1:0]};
   assign new_slot = {hash_ff, ways_ff[WSEL_W-1:0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         hash_ff <= '0;
         ovf_ff  <= 1'b0;
      end else if (cmd.res_ld) begin
         fill_ff <= '0;
         hash_ff <= '0;
         ovf_ff  <= 1'b0;
      end else if (cmd.accept) begin
         if (fill_ff < MAX_FILL) begin
            fill_ff <= fill_ff + LEN_W'(1);
            hash_ff <= hash_ff ^ fold_bytes(loc);
         end else begin
            ovf_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && (fill_ff < MAX_FILL)) begin
         pbuf_mem[fill_ff[IDX_W-1:0]] <= loc;
      end
      if (cmd.wrd_rd) begin
         pbuf_q <= pbuf_mem[idx_ff[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bvalid_ff <= '0;
         ctr_ff    <= '0;
      end else if (cmd.ins) begin
         bvalid_ff[hash_ff] <= 1'b1;
         ctr_ff             <= ctr_ff + ID_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.ins) begin
         bfill_mem[hash_ff] <= ways_ff + WAY_W'(1);
      end
      if (cmd.bfill_rd) begin
         bfill_q  <= bfill_mem[hash_ff];
         bvalid_q <= bvalid_ff[hash_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.ins) begin
         len_mem[new_slot] <= fill_ff;
         id_mem[new_slot]  <= ctr_ff + ID_W'(1);
      end
      if (cmd.ent_rd) begin
         len_q <= len_mem[rd_slot];
         id_q  <= id_mem[rd_slot];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.copy_wr) begin
         words_mem[{new_slot, idx_ff[IDX_W-1:0]}] <= pbuf_q;
      end
      if (cmd.wrd_rd) begin
         word_q <= words_mem[{rd_slot, idx_ff[IDX_W-1:0]}];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.ways_ld) begin
         ways_ff <= bvalid_q ? bfill_q : '0;
         way_ff  <= '0;
      end else if (cmd.way_inc) begin
         way_ff <= way_ff + WAY_W'(1);
      end
      if (cmd.idx_clr || cmd.ins) begin
         idx_ff <= '0;
      end else if (cmd.idx_inc) begin
         idx_ff <= idx_ff + LEN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.res_ld) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.res_ld) begin
         out_id_ff      <= '0;
         out_created_ff <= 1'b0;
         out_status_ff  <= ST_OK;
         case (cmd.res_kind)
            RES_HIT: out_id_ff <= id_q;
            RES_NEW: begin
               out_id_ff      <= ctr_ff;
               out_created_ff <= 1'b1;
            end
            RES_FULL: out_status_ff <= ST_BUCKET_FULL;
            RES_LONG: out_status_ff <= ST_TOO_LONG;
            RES_EXH:  out_status_ff <= ST_EXHAUSTED;
            default:  out_status_ff <= ST_OK;
         endcase
      end
   end

   assign sts.overflow  = ovf_ff;
   assign sts.way_end   = (way_ff == ways_ff);
   assign sts.bkt_full  = (ways_ff >= WAYS_MAX);
   assign sts.exhausted = (ctr_ff == '1);
   assign sts.len_eq    = (len_q == fill_ff);
   assign sts.idx_end   = (idx_ff == fill_ff);
   assign sts.word_eq   = (word_q == pbuf_q);
   assign sts.out_busy  = out_valid_ff && !rsp_ready;

   assign rsp_valid    = out_valid_ff;
   assign rsp_found_id = out_id_ff;
   assign rsp_created  = out_created_ff;
   assign rsp_status   = out_status_ff;

endmodule
`default_nettype wire

FILE: hdl/path_keyed_id_allocator.sv
`default_nettype none
// Path-keyed ID allocator. A path streams in one location per item (place in the upper
// and count in the lower 32 bits) and the item with last set closes it; only that item
// yields a result. Every location up to MAX_PATH_LEN is byte-folded into an 8-bit
// bucket hash and kept in a small path buffer. At the end of the path a controller
// walks the bucket's ways through single-port table memories: for each stored way it
// reads the length, then compares the path one word at a time, so a hit returns the
// stored ID and a miss appends the path under the next counter value. Locations are
// taken back to back while the controller waits for input. A closing item goes through
// its own accept, the bucket fill read, the way count load, a length read per way
// visited, a word read and check per word compared, a word copy per word of an insert
// and the result load; the word memory has a registered read. A path too long for the
// buffer skips the search and goes from the way count load to the result load.
// Overflowing buckets, paths longer than MAX_PATH_LEN and an exhausted ID counter
// return a status code with ID 0 and change nothing. The bucket table is empty after
// reset without any clearing pass, because a valid bit per bucket is cleared by reset.
// The result sits in an output register, so a finished result waiting to be taken does
// not block the next path's locations; only the next path's result load waits for it.
module path_keyed_id_allocator #(
   parameter int MAX_PATH_LEN    = pkia_pkg::DEF_MAX_PATH_LEN,
   parameter int WAYS_PER_BUCKET = pkia_pkg::DEF_WAYS_PER_BUCKET
) (
   input wire logic    clock,
   input wire logic    reset,
   pkia_req_if.sink    req_chan,
   pkia_rsp_if.source  rsp_chan
);
   import pkia_pkg::*;

   pkia_cmd_type cmd;
   pkia_sts_type sts;

   // Sequencer for the search and insert steps.
   pkia_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_last  (req_chan.last),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Path buffer, hash, table memories and the output register.
   pkia_dp #(
      .MAX_PATH_LEN    (MAX_PATH_LEN),
      .WAYS_PER_BUCKET (WAYS_PER_BUCKET)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .req_place    (req_chan.place),
      .req_count    (req_chan.count),
      .rsp_valid    (rsp_chan.valid),
      .rsp_ready    (rsp_chan.ready),
      .rsp_found_id (rsp_chan.found_id),
      .rsp_created  (rsp_chan.created),
      .rsp_status   (rsp_chan.status)
   );

endmodule
`default_nettype wire
